// ----- rtl/i16md_pkg.sv -----
// Package for the intra 16x16 luma mode decision core.
// Holds command codes, mode codes and the decide sequencer state type.
`timescale 1ns / 1ps
`default_nettype none
package i16md_pkg;

  typedef enum logic [2:0] {
    CMD_TOP    = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_CORNER = 3'd2,
    CMD_ORIG   = 3'd3,
    CMD_DECIDE = 3'd4
  } cmd_t;

  localparam logic [1:0] MODE_VERTICAL   = 2'd0;
  localparam logic [1:0] MODE_HORIZONTAL = 2'd1;
  localparam logic [1:0] MODE_DC         = 2'd2;
  localparam logic [1:0] MODE_PLANE      = 2'd3;

  localparam int unsigned EDGE_LEN = 16;
  localparam int unsigned BLK_PIX  = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_GRAD,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/i16md_if.sv -----
// Valid/ready channel interfaces for the intra 16x16 mode decision core.
// Depends on nothing; payload widths follow the item fields.
`timescale 1ns / 1ps
`default_nettype none
interface i16md_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] index;
  logic [7:0] sample;
  logic       left_available;
  logic       up_available;
  modport source (output valid, command, index, sample, left_available, up_available,
                  input ready);
  modport sink   (input valid, command, index, sample, left_available, up_available,
                  output ready);
endinterface

interface i16md_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  best_mode;
  logic [15:0] best_cost;
  modport source (output valid, best_mode, best_cost, input ready);
  modport sink   (input valid, best_mode, best_cost, output ready);
endinterface

interface i16md_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/i16md_plane.sv -----
// Plane prediction sample generator: one registered sample per cycle.
// Uses nothing from i16md_pkg; fed by the top level scan counter.
`timescale 1ns / 1ps
`default_nettype none
module i16md_plane (
  input  wire logic               clk,
  input  wire logic signed [13:0] a,
  input  wire logic signed [15:0] b,
  input  wire logic signed [15:0] c,
  input  wire logic [3:0]         x,
  input  wire logic [3:0]         y,
  output logic [7:0]              pred
);
  logic signed [4:0]  xo;
  logic signed [4:0]  yo;
  logic signed [22:0] acc;
  logic signed [17:0] shf;

  // Form a + b*(x-7) + c*(y-7) + 16, then floor shift and clip
  always_comb begin
    xo  = $signed({1'b0, x}) - 5'sd7;
    yo  = $signed({1'b0, y}) - 5'sd7;
    acc = 23'(a) + 23'(b * xo) + 23'(c * yo) + 23'sd16;
    shf = 18'(acc >>> 5);
  end

  // Register the clipped sample
  always_ff @(posedge clk) begin
    if (shf < 0) pred <= 8'd0;
    else if (shf > 18'sd255) pred <= 8'd255;
    else pred <= shf[7:0];
  end
endmodule
`default_nettype wire

// ----- rtl/intra16_luma_mode_decision_core.sv -----
// Top level of the intra 16x16 luma mode decision core.
// Depends on i16md_pkg, i16md_if (channel interfaces) and i16md_plane.
`timescale 1ns / 1ps
`default_nettype none
// Load beats (top, left, corner, original pixel) are taken one per cycle while
// the core is idle and write straight into storage. A decide beat runs a
// sequencer: ST_EDGE walks the edge memories for sums and plane gradients
// (16 reads, read data registered), ST_GRAD forms the gradients and the DC
// value, then ST_SCAN reads one original pixel per cycle from its single-port
// memory and accumulates all four SADs side by side, ST_DRAIN lets the scan
// pipeline empty and ST_PICK picks the mode. The result waits in an output
// register; input is taken again once res_valid has cleared and the state is
// back at ST_IDLE. No input is taken while a decide is in progress.
module intra16_luma_mode_decision_core (
  input  wire logic clk,
  input  wire logic rst,
  i16md_in_if.sink   in_ch,
  i16md_out_if.source out_ch,
  i16md_cfg_if.sink  cfg
);
  // Edge and block memories, read data registered
  logic [7:0] top_mem  [16];
  logic [7:0] left_mem [16];
  logic [7:0] orig_mem [256];
  logic [7:0] corner;
  logic [7:0] top_rd, left_rd, orig_rd;
  logic [7:0] dc_fallback;

  i16md_pkg::state_t state, state_next;
  logic [7:0] cnt;
  logic [3:0] rd_x;
  logic [3:0] rd_y;
  logic       left_ok, up_ok;
  logic [11:0] sum_t, sum_l;
  logic signed [14:0] h_acc, v_acc;
  logic signed [13:0] a_val;
  logic signed [15:0] b_val, c_val;
  logic [7:0]  dc_val;
  logic [15:0] sad_v, sad_h, sad_dc, sad_p;
  logic        scan_v;
  logic [7:0]  scan_x;
  logic [7:0]  plane_pred;
  logic [1:0]  res_mode;
  logic [15:0] res_cost;
  logic        res_valid;
  logic [3:0]  e_idx;
  logic signed [4:0] wgt;
  logic signed [8:0] td, ld;
  logic        acc_beat;
  logic [7:0]  rd_addr;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == i16md_pkg::ST_IDLE);
  assign acc_beat = in_ch.valid && in_ch.ready;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) dc_fallback <= 8'd128;
    else if (cfg.valid) dc_fallback <= cfg.data;
  end

  // Edge walk index: during ST_EDGE read entry cnt
  assign e_idx   = cnt[3:0];
  assign rd_addr = cnt;

  // Memory writes and registered reads
  always_ff @(posedge clk) begin
    if (acc_beat && in_ch.command == i16md_pkg::CMD_TOP && in_ch.index[7:4] == 4'd0)
      top_mem[in_ch.index[3:0]] <= in_ch.sample;
    if (acc_beat && in_ch.command == i16md_pkg::CMD_LEFT && in_ch.index[7:4] == 4'd0)
      left_mem[in_ch.index[3:0]] <= in_ch.sample;
    if (acc_beat && in_ch.command == i16md_pkg::CMD_CORNER)
      corner <= in_ch.sample;
    if (acc_beat && in_ch.command == i16md_pkg::CMD_ORIG)
      orig_mem[in_ch.index] <= in_ch.sample;
    top_rd  <= top_mem[(state == i16md_pkg::ST_SCAN) ? rd_addr[3:0] : e_idx];
    left_rd <= left_mem[(state == i16md_pkg::ST_SCAN) ? rd_addr[7:4] : e_idx];
    orig_rd <= orig_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      i16md_pkg::ST_IDLE:
        if (acc_beat && in_ch.command == i16md_pkg::CMD_DECIDE)
          state_next = i16md_pkg::ST_EDGE;
      i16md_pkg::ST_EDGE:  if (cnt == 8'd16) state_next = i16md_pkg::ST_GRAD;
      i16md_pkg::ST_GRAD:  state_next = i16md_pkg::ST_SCAN;
      i16md_pkg::ST_SCAN:  if (cnt == 8'd255) state_next = i16md_pkg::ST_DRAIN;
      i16md_pkg::ST_DRAIN: if (!scan_v) state_next = i16md_pkg::ST_PICK;
      i16md_pkg::ST_PICK:  state_next = i16md_pkg::ST_OUT;
      i16md_pkg::ST_OUT:   if (!res_valid) state_next = i16md_pkg::ST_IDLE;
      default:             state_next = i16md_pkg::ST_IDLE;
    endcase
  end

  // Edge weights: entry e contributes (e-7) for e>=8 and -(7-e) below 7
  always_comb begin
    wgt = $signed({1'b0, rd_x}) - 5'sd7;
    td  = $signed({1'b0, top_rd});
    ld  = $signed({1'b0, left_rd});
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i16md_pkg::ST_IDLE;
      cnt <= '0;
      scan_v <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        i16md_pkg::ST_IDLE: begin
          cnt <= '0;
          if (acc_beat) begin
            left_ok <= in_ch.left_available;
            up_ok   <= in_ch.up_available;
          end
          sum_t <= '0; sum_l <= '0; h_acc <= '0; v_acc <= '0;
        end
        i16md_pkg::ST_EDGE: begin
          rd_x <= e_idx;
          if (cnt != 8'd0) begin
            sum_t <= sum_t + 12'(top_rd);
            sum_l <= sum_l + 12'(left_rd);
          end
          if (cnt == 8'd16) begin
            // rd_x==15 weight 8 was applied as 8*top15; subtract corner
            h_acc <= h_acc + 15'(wgt) * 15'(td) - 15'sd8 * $signed({7'd0, corner});
            v_acc <= v_acc + 15'(wgt) * 15'(ld) - 15'sd8 * $signed({7'd0, corner});
            a_val <= 14'sd16 * ($signed({6'd0, left_rd}) + $signed({6'd0, top_rd}));
            cnt <= '0;
          end else begin
            cnt <= cnt + 8'd1;
            if (cnt != 8'd0 && rd_x != 4'd7) begin
              h_acc <= h_acc + 15'(wgt) * 15'(td);
              v_acc <= v_acc + 15'(wgt) * 15'(ld);
            end
          end
        end
        i16md_pkg::ST_GRAD: begin
          b_val <= 16'((18'sd5 * 18'(h_acc) + 18'sd32) >>> 6);
          c_val <= 16'((18'sd5 * 18'(v_acc) + 18'sd32) >>> 6);
          if (left_ok && up_ok) dc_val <= 8'((13'(sum_t) + 13'(sum_l) + 13'd16) >> 5);
          else if (left_ok) dc_val <= 8'((sum_l + 12'd8) >> 4);
          else if (up_ok) dc_val <= 8'((sum_t + 12'd8) >> 4);
          else dc_val <= dc_fallback;
          sad_v <= '0; sad_h <= '0; sad_dc <= '0; sad_p <= '0;
          cnt <= '0;
        end
        i16md_pkg::ST_SCAN: begin
          cnt <= cnt + 8'd1;
        end
        i16md_pkg::ST_PICK: begin
          res_valid <= 1'b1;
          if (up_ok && !(left_ok && sad_h < sad_v) && sad_v <= sad_dc &&
              !(left_ok && up_ok && sad_p < sad_v)) begin
            res_mode <= i16md_pkg::MODE_VERTICAL; res_cost <= sad_v;
          end else if (left_ok && sad_h <= sad_dc && !(up_ok && sad_v <= sad_h) &&
                       !(up_ok && sad_p < sad_h)) begin
            res_mode <= i16md_pkg::MODE_HORIZONTAL; res_cost <= sad_h;
          end else if (left_ok && up_ok && sad_p < sad_dc) begin
            res_mode <= i16md_pkg::MODE_PLANE; res_cost <= sad_p;
          end else begin
            res_mode <= i16md_pkg::MODE_DC; res_cost <= sad_dc;
          end
        end
        i16md_pkg::ST_OUT: begin
          if (out_ch.ready) res_valid <= 1'b0;
        end
        default: ;
      endcase
      // Scan pipeline: read issued this cycle, data next cycle
      scan_v <= (state == i16md_pkg::ST_SCAN);
      if (state == i16md_pkg::ST_SCAN) scan_x <= cnt;
      if (scan_v) begin
        sad_v  <= sad_v  + 16'(orig_rd > top_rd ? orig_rd - top_rd : top_rd - orig_rd);
        sad_h  <= sad_h  + 16'(orig_rd > left_rd ? orig_rd - left_rd : left_rd - orig_rd);
        sad_dc <= sad_dc + 16'(orig_rd > dc_val ? orig_rd - dc_val : dc_val - orig_rd);
        sad_p  <= sad_p  + 16'(orig_rd > plane_pred ? orig_rd - plane_pred
                                                    : plane_pred - orig_rd);
      end
    end
  end

  assign rd_y = cnt[7:4];

  i16md_plane u_plane (
    .clk  (clk),
    .a    (a_val),
    .b    (b_val),
    .c    (c_val),
    .x    (cnt[3:0]),
    .y    (rd_y),
    .pred (plane_pred)
  );

  assign out_ch.valid     = res_valid && (state == i16md_pkg::ST_OUT);
  assign out_ch.best_mode = res_mode;
  assign out_ch.best_cost = res_cost;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != i16md_pkg::ST_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_out_only: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (state == i16md_pkg::ST_OUT)) else $error("stray result");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    $fell(scan_v) |-> (scan_x == 8'd255)) else $error("scan cut short");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_intra16_scoreboard.sv -----
// Mode decision predictor and scoreboard for the intra 16x16 luma core.
// Depends on i16md_pkg for command and mode codes.
`timescale 1ns / 1ps
package tb_intra16_scoreboard_pkg;
  import i16md_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cost;
  } decision_t;

  class mode_decision_board;
    logic [7:0] top_px [16];
    logic [7:0] left_px [16];
    logic [7:0] corner_px;
    logic [7:0] orig_px [256];
    logic [7:0] dc_fallback;
    decision_t  pending_decisions [$];
    int         mismatches;
    int         decisions_checked;

    function new();
      foreach (top_px[i]) top_px[i] = '0;
      foreach (left_px[i]) left_px[i] = '0;
      foreach (orig_px[i]) orig_px[i] = '0;
      corner_px = '0;
      dc_fallback = 8'd128;
      mismatches = 0;
      decisions_checked = 0;
    endfunction

    // Floor division by a power of two, for signed values.
    function int floor_shr(int v, int n);
      return v >>> n;
    endfunction

    function int sad_of(logic [1:0] mode, int dc, int a, int b, int c);
      int sad;
      int p;
      int o;
      sad = 0;
      for (int y = 0; y < 16; y++) begin
        for (int x = 0; x < 16; x++) begin
          case (mode)
            MODE_VERTICAL: p = top_px[x];
            MODE_HORIZONTAL: p = left_px[y];
            MODE_DC: p = dc;
            default: begin
              p = floor_shr(a + b * (x - 7) + c * (y - 7) + 16, 5);
              if (p < 0) p = 0;
              if (p > 255) p = 255;
            end
          endcase
          o = orig_px[y * 16 + x];
          sad += (o > p) ? o - p : p - o;
        end
      end
      return sad;
    endfunction

    // Note an accepted input beat; queue a decision on decide.
    function void note_input(logic [2:0] cmd, logic [7:0] idx, logic [7:0] smp,
                             logic lok, logic uok);
      int sum_t, sum_l, dc, a, b, c, h, v, cost;
      bit have;
      decision_t d;
      sum_t = 0; sum_l = 0; a = 0; b = 0; c = 0; have = 0;
      d = '0;
      case (cmd)
        CMD_TOP: if (idx < 16) top_px[idx] = smp;
        CMD_LEFT: if (idx < 16) left_px[idx] = smp;
        CMD_CORNER: corner_px = smp;
        CMD_ORIG: orig_px[idx] = smp;
        CMD_DECIDE: begin
          for (int i = 0; i < 16; i++) begin
            sum_t += top_px[i];
            sum_l += left_px[i];
          end
          if (lok && uok) dc = (sum_t + sum_l + 16) >> 5;
          else if (lok) dc = (sum_l + 8) >> 4;
          else if (uok) dc = (sum_t + 8) >> 4;
          else dc = dc_fallback;
          if (lok && uok) begin
            h = 8 * (int'(top_px[15]) - int'(corner_px));
            v = 8 * (int'(left_px[15]) - int'(corner_px));
            for (int i = 0; i < 7; i++) begin
              h += (i + 1) * (int'(top_px[8 + i]) - int'(top_px[6 - i]));
              v += (i + 1) * (int'(left_px[8 + i]) - int'(left_px[6 - i]));
            end
            a = 16 * (int'(left_px[15]) + int'(top_px[15]));
            b = floor_shr(5 * h + 32, 6);
            c = floor_shr(5 * v + 32, 6);
          end
          d.mode = MODE_DC;
          for (int m = 0; m < 4; m++) begin
            if (m == MODE_VERTICAL && !uok) continue;
            if (m == MODE_HORIZONTAL && !lok) continue;
            if (m == MODE_PLANE && !(lok && uok)) continue;
            cost = sad_of(m[1:0], dc, a, b, c);
            if (!have || cost < d.cost) begin
              have = 1;
              d.cost = cost[15:0];
              d.mode = m[1:0];
            end
          end
          pending_decisions.push_back(d);
        end
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      $display("mismatch %0s: got %0d want %0d", what, got, want);
    endtask

    // Compare one result beat with the oldest pending decision.
    task check_result(logic [1:0] mode, logic [15:0] cost);
      decision_t d;
      if (pending_decisions.size() == 0) begin
        report("unexpected result mode", int'(mode), -1);
        return;
      end
      d = pending_decisions.pop_front();
      decisions_checked++;
      if (mode !== d.mode) report("best_mode", int'(mode), int'(d.mode));
      if (cost !== d.cost) report("best_cost", int'(cost), int'(d.cost));
    endtask
  endclass
endpackage

// ----- tb/tb.sv -----
// Testbench top for intra16_luma_mode_decision_core: loads macroblocks,
// issues decides and checks each decision. Depends on i16md_pkg, i16md_if and tb_intra16_scoreboard_pkg.
`timescale 1ns / 1ps
module tb;
  import i16md_pkg::*;
  import tb_intra16_scoreboard_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   send_idle_pct = 7;
  int   recv_idle_pct = 75;
  int   hold_off_cycles = 0;
  mode_decision_board board = new();

  i16md_in_if  in_ch();
  i16md_out_if out_ch();
  i16md_cfg_if cfg();

  intra16_luma_mode_decision_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.command = '0; in_ch.index = '0; in_ch.sample = '0;
    in_ch.left_available = 0; in_ch.up_available = 0;
    cfg.valid = 0; cfg.data = '0;
    out_ch.ready = 0;
  end

  // Receiver: random stalls, plus an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result beat at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.best_mode, out_ch.best_cost);
  end

  // Offer one beat; valid stays high into the next beat unless the sender idles.
  task automatic send_beat(logic [2:0] cmd, logic [7:0] idx, logic [7:0] smp,
                           logic lok, logic uok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.command <= cmd; in_ch.index <= idx;
    in_ch.sample <= smp; in_ch.left_available <= lok; in_ch.up_available <= uok;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(cmd, idx, smp, lok, uok);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (board.pending_decisions.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_fallback(logic [7:0] val);
    cfg.valid <= 1; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    board.dc_fallback = val;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  // Load edges, corner and the first pix_count original pixels; kind picks
  // flat, extreme or random content.
  task automatic load_block(int kind, int pix_count, ref int sent);
    logic [7:0] s;
    for (int i = 0; i < 16; i++) begin
      s = (kind == 1) ? 8'hFF : (kind == 2) ? 8'h00 : 8'($urandom);
      send_beat(CMD_TOP, 8'(i), s, 1'($urandom), 1'($urandom));
      s = (kind == 1) ? 8'h00 : (kind == 2) ? 8'hFF : 8'($urandom);
      send_beat(CMD_LEFT, 8'(i), s, 1'($urandom), 1'($urandom));
      sent += 2;
    end
    send_beat(CMD_CORNER, 8'($urandom), (kind == 1) ? 8'h00 : 8'($urandom), 1'b0, 1'b0);
    for (int p = 0; p < pix_count; p++) begin
      s = (kind == 1) ? ((p[0]) ? 8'hFF : 8'h00) : (kind == 2) ? 8'h80 : 8'($urandom);
      send_beat(CMD_ORIG, 8'(p), s, 1'b0, 1'b0);
    end
    sent += 1 + pix_count;
  endtask

  initial begin
    int sent;
    sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, all availability pairs, ignored commands.
    load_block(1, 256, sent);
    for (int k = 0; k < 4; k++) send_beat(CMD_DECIDE, 8'hFF, 8'hFF, k[0], k[1]);
    send_beat(CMD_TOP, 8'd16, 8'hAA, 1'b1, 1'b1);
    send_beat(CMD_LEFT, 8'hFF, 8'h55, 1'b1, 1'b1);
    send_beat(3'd5, 8'd0, 8'd0, 1'b0, 1'b0);
    send_beat(3'd6, 8'd0, 8'd0, 1'b0, 1'b0);
    send_beat(3'd7, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_beat(CMD_DECIDE, 8'd0, 8'd0, 1'b1, 1'b1);
    wait_drained();
    write_fallback(8'h00);
    send_beat(CMD_DECIDE, 8'd0, 8'd0, 1'b0, 1'b0);
    wait_drained();
    write_fallback(8'hFF);
    send_beat(CMD_DECIDE, 8'd0, 8'd0, 1'b0, 1'b0);
    load_block(2, 256, sent);
    for (int k = 0; k < 4; k++) send_beat(CMD_DECIDE, 8'd0, 8'd0, k[0], k[1]);

    // Long receiver hold-off while decides keep coming.
    wait_drained();
    hold_off_cycles = 2000;
    for (int k = 0; k < 6; k++) send_beat(CMD_DECIDE, 8'd0, 8'd0, k[0], 1'b1);

    // Random macroblocks across three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 7 : 0;
      wait_drained();
      write_fallback(8'($urandom));
      load_block(0, 192, sent);
      for (int k = 0; k < 4; k++) begin
        // Occasional stray edge, corner, pixel and unknown-command beats between decides.
        if ($urandom_range(3) == 0) begin
          send_beat(CMD_TOP, 8'($urandom_range(31)), 8'($urandom), 1'($urandom),
                    1'($urandom));
          send_beat(CMD_LEFT, 8'($urandom_range(31)), 8'($urandom), 1'($urandom),
                    1'($urandom));
          send_beat(CMD_CORNER, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
          send_beat(CMD_ORIG, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
          send_beat(3'($urandom_range(7, 5)), 8'($urandom), 8'($urandom), 1'b0, 1'b0);
        end
        send_beat(CMD_DECIDE, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end

    wait_drained();
    $display("covered %0d load beats and %0d decisions over three idle profiles",
             sent, board.decisions_checked);
    $display("fallback written at both extremes; one long output hold-off");
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end
endmodule
